>>> rtl/fcrc_pkg.sv
package fcrc_pkg;

   // CRC-32/MPEG-2 computed as bit-reversed bytes through the reflected update
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One classified request: payload byte and, for a closing request, the final CRC
   typedef struct packed {
      logic [7:0]  data;
      logic        has_byte;
      logic        eof;
      logic [31:0] crc;
   } fcrc_entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic nonempty;
   } fcrc_qstat_type;

   // Mirror the bit order of a byte
   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   // One byte of the reflected table update, done bitwise
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] t;
      t = {24'h00_0000, crc[7:0] ^ b};
      for (int j = 0; j < 8; j++) begin
         t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
      end
      return {8'h00, crc[31:8]} ^ t;
   endfunction

endpackage

>>> rtl/frame_crc32_append_core.sv
// Channel   Dir  tdata               tuser              tlast
// req_      in   [7:0] data_byte     [0] carries_byte   end_of_frame
// rsp_      out  [7:0] out_byte      [0] is_check_byte  frame_last
//
// Requests are taken at one per cycle while the 4-entry queue has room; the CRC
// update happens at acceptance, one table step per byte.
// Results leave one per cycle unless stalled: 1 for a payload byte, 4 more for a close.
// With an idle queue a result is written to a queue slot, then to the output register.
// Reset sets the CRC register to all ones and empties queue and output register.
// A stalled result stays registered; the front keeps accepting until the queue fills.
module frame_crc32_append_core
   import fcrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [0:0] req_tuser,   // [0] carries_byte
   input  logic       req_tlast,   // end_of_frame
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [0:0] rsp_tuser,   // [0] is_check_byte
   output logic       rsp_tlast    // frame_last
);

   fcrc_qstat_type qstat;
   fcrc_entry_type push_entry;
   fcrc_entry_type head;
   logic           push;
   logic           pop;

   fcrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   fcrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   fcrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/fcrc_front.sv
module fcrc_front
   import fcrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // [7:0] data_byte
   input  logic [0:0]     req_tuser,   // [0] carries_byte
   input  logic           req_tlast,   // end_of_frame
   input  fcrc_qstat_type qstat,
   output logic           push,
   output fcrc_entry_type push_entry
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [31:0] crc_next;
   logic        accept;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   // Fold the payload byte, bit-reversed
   always_comb begin
      crc_next = req_tuser[0] ? crc_fold(crc_ff, rev8(req_tdata)) : crc_ff;
   end

   // Empty requests are dropped here; the rest go to the queue
   assign push                = accept && (req_tuser[0] || req_tlast);
   assign push_entry.data     = req_tdata;
   assign push_entry.has_byte = req_tuser[0];
   assign push_entry.eof      = req_tlast;
   assign push_entry.crc      = crc_next;

   // Register restarts after a frame closes
   always_comb begin
      crc_in = crc_ff;
      if (accept) begin
         crc_in = req_tlast ? CRC_INIT : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

>>> rtl/fcrc_queue.sv
module fcrc_queue
   import fcrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  fcrc_entry_type push_entry,
   input  logic           pop,
   output fcrc_entry_type head,
   output fcrc_qstat_type qstat
);

   fcrc_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff,  count_in;

   assign qstat.full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign qstat.nonempty = (count_ff != '0);
   assign head           = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/fcrc_back.sv
module fcrc_back
   import fcrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  fcrc_entry_type head,
   input  fcrc_qstat_type qstat,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,   // [7:0] out_byte
   output logic [0:0]     rsp_tuser,   // [0] is_check_byte
   output logic           rsp_tlast    // frame_last
);

   // Result index within one entry: payload byte, then CRC bytes low first
   localparam logic [2:0] STEP_DATA = 3'd0;
   localparam logic [2:0] STEP_CRC0 = 3'd1;
   localparam logic [2:0] STEP_CRC1 = 3'd2;
   localparam logic [2:0] STEP_CRC2 = 3'd3;
   localparam logic [2:0] STEP_CRC3 = 3'd4;

   logic [2:0] step_ff, step_in;
   logic [2:0] step_now;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       chk_ff, chk_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_step;

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = chk_ff;
   assign rsp_tlast    = last_ff;

   // Output register takes a new result when empty or being drained
   assign load = qstat.nonempty && (!valid_ff || rsp_tready);

   // Skip the payload slot for a CRC-only entry
   always_comb begin
      step_now = step_ff;
      if (step_ff == STEP_DATA && !head.has_byte) begin
         step_now = STEP_CRC0;
      end
   end

   assign final_step = (step_now == STEP_CRC3) || (step_now == STEP_DATA && !head.eof);
   assign pop        = load && final_step;

   // Select the result for this step
   always_comb begin
      data_in = data_ff;
      chk_in  = chk_ff;
      last_in = last_ff;
      if (load) begin
         chk_in  = (step_now != STEP_DATA);
         last_in = (step_now == STEP_CRC3);
         case (step_now)
            STEP_DATA: data_in = head.data;
            STEP_CRC0: data_in = rev8(head.crc[7:0]);
            STEP_CRC1: data_in = rev8(head.crc[15:8]);
            STEP_CRC2: data_in = rev8(head.crc[23:16]);
            STEP_CRC3: data_in = rev8(head.crc[31:24]);
            default:   data_in = head.data;
         endcase
      end
   end

   // Step and valid control
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = final_step ? STEP_DATA : step_now + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_DATA;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      chk_ff  <= chk_in;
      last_ff <= last_in;
   end

endmodule

>>> rtl/fcrc_checker.sv
module fcrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic [0:0] req_tuser,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Frame end only on a CRC byte
   a_last_is_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("frame_last on a payload byte");

   // Reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Queue is empty after reset, so requests are taken
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready after reset");

endmodule

bind frame_crc32_append_core fcrc_checker u_fcrc_checker (.*);

>>> dv/testbench.sv
import fcrc_pkg::*;

// One result as it leaves the block
typedef struct packed {
   logic [7:0] out_byte;
   logic       is_check;
   logic       frame_last;
} crc_out_t;

// Running CRC-32/MPEG-2 of the open frame and the results still owed by the block
class crc_scoreboard;
   logic [31:0] frame_crc;
   crc_out_t    owed_q[$];
   int          error_count;

   function new();
      frame_crc   = CRC_INIT;
      error_count = 0;
   endfunction

   task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Byte with its bit order flipped
   function logic [7:0] mirror(logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   // Serial reflected LFSR, fed the payload byte MSB first
   function logic [31:0] advance(logic [31:0] c, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[7-i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Accepted request: queue pass-through byte, then the four CRC bytes on a frame close
   task note_request(logic [7:0] data, logic has_byte, logic eof);
      if (has_byte) begin
         owed_q.push_back('{data, 1'b0, 1'b0});
         frame_crc = advance(frame_crc, data);
      end
      if (eof) begin
         for (int k = 0; k < 4; k++) begin
            owed_q.push_back('{mirror(frame_crc[8*k +: 8]), 1'b1, (k == 3)});
         end
         frame_crc = CRC_INIT;
      end
   endtask

   task check_response(logic [7:0] b, logic chk, logic last);
      crc_out_t want;
      if (owed_q.size() == 0) begin
         report($sformatf("unexpected result byte=%02h chk=%0b last=%0b", b, chk, last));
      end else begin
         want = owed_q.pop_front();
         if (b !== want.out_byte)
            report($sformatf("out_byte %02h, wanted %02h", b, want.out_byte));
         if (chk !== want.is_check)
            report($sformatf("is_check_byte %0b, wanted %0b", chk, want.is_check));
         if (last !== want.frame_last)
            report($sformatf("frame_last %0b, wanted %0b", last, want.frame_last));
      end
   endtask

   task drain_check();
      crc_out_t left;
      while (owed_q.size() != 0) begin
         left = owed_q.pop_front();
         report($sformatf("missing result byte=%02h chk=%0b last=%0b",
                          left.out_byte, left.is_check, left.frame_last));
      end
   endtask

   function int pending();
      return owed_q.size();
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ITEMS      = 280;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic [0:0] req_tuser  = 1'b0;    // [0] carries_byte
   logic       req_tlast  = 1'b0;    // end_of_frame
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [0:0] rsp_tuser;            // [0] is_check_byte
   logic       rsp_tlast;            // frame_last

   crc_scoreboard sb = new();

   int idle_cycles     = 0;
   int items_sent      = 0;
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   bit hold_off        = 1'b0;

   frame_crc32_append_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offer one request after a random gap, hold it until taken
   task automatic send_request(input logic [7:0] d, input logic has, input logic eof);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= has;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      if (has || eof) items_sent++;
   endtask

   task automatic send_bytes(input string s, input logic close);
      for (int i = 0; i < s.len(); i++) begin
         send_request(s[i], 1'b1, close && (i == s.len() - 1));
      end
   endtask

   // Random frame; sometimes closed by a bare end-of-frame request, with empty requests mixed in
   task automatic send_frame(input int len);
      bit close_alone;
      close_alone = (len == 0) || ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !close_alone);
      end
      if (close_alone)
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Receiver: random stall per result, one long hold-off on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            stall    = HOLD_CYCLES;
            hold_off = 1'b0;
         end else begin
            stall = receiver_steady ? 0 : $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Handshake monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser[0], rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata, req_tuser[0], req_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int  len;
      bit  hold_used;
      hold_used = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty frame, ignored empty request, check string, byte extremes
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hA5, 1'b0, 1'b0);
      send_bytes("123456789", 1'b1);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);
      send_request(8'hAA, 1'b1, 1'b0);
      send_request(8'h55, 1'b1, 1'b0);
      send_request(8'h3C, 1'b0, 1'b0);
      send_request(8'hC3, 1'b0, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1);
      send_request(8'hFF, 1'b0, 1'b1);

      // Random frames, with steady stretches on either side
      while (items_sent < NUM_ITEMS) begin
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         if (!hold_used && items_sent >= 120) begin
            // Receiver stops for a long stretch while requests keep coming
            hold_off        = 1'b1;
            hold_used       = 1'b1;
            sender_steady   = 1'b1;
            receiver_steady = 1'b0;
         end
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
         send_frame(len);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.drain_check();
      if (sb.error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
rtl/fcrc_pkg.sv
rtl/fcrc_front.sv
rtl/fcrc_queue.sv
rtl/fcrc_back.sv
rtl/frame_crc32_append_core.sv
rtl/fcrc_checker.sv
dv/testbench.sv
